FILE: rtl/pqct_pkg.sv
// ----------------------------------------------------------------------------
// pqct_pkg
// Shared types, constants and helpers for the page quota container table:
// request and response beats, the classified command passed from the front
// end to the back end, and the packed table entry.
// ----------------------------------------------------------------------------
package pqct_pkg;

  localparam int TABLE_SIZE = 64;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int PAGE_W     = 21;
  localparam int CMD_W      = 3;
  localparam int ID_W       = 8;
  localparam int PARENT_W   = 6;
  localparam int CHILD_W    = 7;
  localparam int CAND_W     = 9;

  // command codes on the request beat
  localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SPLIT   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CHARGE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INIT    = 3'd4;

  // classified operation kinds
  localparam logic [2:0] K_CHECK   = 3'd0;
  localparam logic [2:0] K_SPLIT   = 3'd1;
  localparam logic [2:0] K_CHARGE  = 3'd2;
  localparam logic [2:0] K_RELEASE = 3'd3;
  localparam logic [2:0] K_INIT    = 3'd4;
  localparam logic [2:0] K_NOP     = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [PAGE_W-1:0] amount;
    logic              release_valid;
  } req_t;

  typedef struct packed {
    logic                ok;
    logic [CHILD_W-1:0]  new_child;
    logic [PAGE_W-1:0]   entry_quota;
    logic [PAGE_W-1:0]   entry_usage;
    logic [PARENT_W-1:0] entry_parent;
    logic [CHILD_W-1:0]  entry_children;
    logic                entry_in_use;
  } rsp_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic              in_range;
    logic [IDX_W-1:0]  idx;
    logic [PAGE_W-1:0] amount;
  } op_t;

  typedef struct packed {
    logic [PAGE_W-1:0]   quota;
    logic [PAGE_W-1:0]   usage;
    logic [PARENT_W-1:0] parent;
    logic [CHILD_W-1:0]  children;
    logic                in_use;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // contents of an entry that has not been written since reset or init
  function automatic entry_t blank_entry(input logic [IDX_W-1:0] idx);
    entry_t e;
    e        = '0;
    e.in_use = (idx == '0);
    return e;
  endfunction

endpackage

FILE: rtl/pqct_ram.sv
// ----------------------------------------------------------------------------
// pqct_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pqct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/pqct_front.sv
// ----------------------------------------------------------------------------
// pqct_front
// Request front end: accepts request beats, classifies the command and the
// id range, and holds classified operations in a two-entry queue.
// ----------------------------------------------------------------------------
module pqct_front
  import pqct_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic q_valid,
  output op_t  q_data,
  input  logic q_pop
);

  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       push;
  logic       in_range;
  op_t        op;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_data   = slots[rd_ptr];
  assign in_range = (in_data.id < ID_W'(TABLE_SIZE));

  always_comb begin
    op.in_range = in_range;
    op.idx      = in_data.id[IDX_W-1:0];
    op.amount   = in_data.amount;
    unique case (in_data.cmd)
      CMD_CHECK:   op.kind = K_CHECK;
      CMD_SPLIT:   op.kind = K_SPLIT;
      CMD_CHARGE:  op.kind = K_CHARGE;
      CMD_RELEASE: op.kind = in_data.release_valid ? K_RELEASE : K_NOP;
      CMD_INIT:    op.kind = K_INIT;
      default:     op.kind = K_NOP;
    endcase
  end

  always_comb begin
    count_next = count;
    if (push && !q_pop) begin
      count_next = count + 2'd1;
    end else if (!push && q_pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= op;
    end
  end

endmodule

FILE: rtl/pqct_back.sv
// ----------------------------------------------------------------------------
// pqct_back
// Back end: reads the addressed entry, applies the operation, writes the
// entry back (and the new child entry for a split) and registers the response.
// ----------------------------------------------------------------------------
module pqct_back
  import pqct_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  op_t               q_data,
  output logic              q_pop,
  input  logic [PAGE_W-1:0] root_quota,
  output logic              out_valid,
  input  logic              out_ready,
  output rsp_t              out_data
);

  localparam logic [1:0] ST_FETCH = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_CHILD = 2'd2;

  logic [1:0]            state;
  logic [1:0]            state_next;
  op_t                   cur;
  logic [TABLE_SIZE-1:0] valid_bits;
  logic [IDX_W-1:0]      child_addr;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;

  entry_t                ent;
  entry_t                upd;
  entry_t                root_ent;
  entry_t                child_ent;
  logic                  fire;
  logic                  fits_amt;
  logic                  fits_one;
  logic [CAND_W-1:0]     cand;
  logic                  split_ok;
  logic [PAGE_W:0]       sum;
  logic                  write_upd;
  rsp_t                  res;

  pqct_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SIZE)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (q_pop),
    .raddr(q_data.idx),
    .rdata(ram_rdata)
  );

  assign q_pop = (state == ST_FETCH) && q_valid;
  assign fire  = (state == ST_EXEC) && (!out_valid || out_ready);

  always_comb begin
    ent       = valid_bits[cur.idx] ? entry_t'(ram_rdata) : blank_entry(cur.idx);
    root_ent        = '0;
    root_ent.quota  = root_quota;
    root_ent.in_use = 1'b1;
    child_ent          = '0;
    child_ent.quota    = cur.amount;
    child_ent.parent   = PARENT_W'(cur.idx);
    child_ent.in_use   = 1'b1;

    fits_amt = (ent.usage <= ent.quota) && ((ent.quota - ent.usage) >= cur.amount);
    fits_one = (ent.usage < ent.quota);
    cand     = CAND_W'(cur.idx) + CAND_W'(ent.children) + CAND_W'(1);
    split_ok = cur.in_range && (cand < CAND_W'(TABLE_SIZE));
    sum      = {1'b0, ent.usage} + {1'b0, cur.amount};

    upd       = ent;
    write_upd = 1'b0;
    res       = '0;
    unique case (cur.kind)
      K_CHECK: begin
        res.ok = cur.in_range && fits_amt;
      end
      K_SPLIT: begin
        res.new_child = CHILD_W'(TABLE_SIZE);
        if (split_ok) begin
          upd.children  = ent.children + CHILD_W'(1);
          upd.usage     = sum[PAGE_W] ? '1 : sum[PAGE_W-1:0];
          write_upd     = 1'b1;
          res.ok        = 1'b1;
          res.new_child = CHILD_W'(cand);
        end
      end
      K_CHARGE: begin
        if (cur.in_range && fits_one) begin
          upd.usage = ent.usage + PAGE_W'(1);
          write_upd = 1'b1;
          res.ok    = 1'b1;
        end
      end
      K_RELEASE: begin
        if (cur.in_range) begin
          upd.usage = ent.usage - PAGE_W'(ent.usage != '0);
          write_upd = 1'b1;
          res.ok    = 1'b1;
        end
      end
      K_INIT: begin
        upd    = (cur.idx == '0) ? root_ent : entry_t'('0);
        res.ok = 1'b1;
      end
      default: begin
      end
    endcase

    if (cur.in_range) begin
      res.entry_quota    = upd.quota;
      res.entry_usage    = upd.usage;
      res.entry_parent   = upd.parent;
      res.entry_children = upd.children;
      res.entry_in_use   = upd.in_use;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur.idx;
    ram_wdata = ENTRY_W'(upd);
    if (state == ST_CHILD) begin
      ram_we    = 1'b1;
      ram_waddr = child_addr;
      ram_wdata = ENTRY_W'(child_ent);
    end else if (fire && cur.kind == K_INIT) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
      ram_wdata = ENTRY_W'(root_ent);
    end else if (fire && write_upd) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_FETCH: if (q_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        if (fire) begin
          state_next = (cur.kind == K_SPLIT && split_ok) ? ST_CHILD : ST_FETCH;
        end
      end
      ST_CHILD: state_next = ST_FETCH;
      default:  state_next = ST_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FETCH;
      out_valid  <= 1'b0;
      valid_bits <= '0;
    end else begin
      state <= state_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (fire && cur.kind == K_INIT) begin
        valid_bits <= TABLE_SIZE'(1);
      end else if (ram_we) begin
        valid_bits[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (fire) begin
      out_data   <= res;
      child_addr <= cand[IDX_W-1:0];
    end
  end

endmodule

FILE: rtl/page_quota_container_table.sv
// ----------------------------------------------------------------------------
// page_quota_container_table
// Timing: an accepted request beat is queued, popped into the back end and
// executed into the output register, once that register is free.
// The back end starts a command only when done with the last (read, update);
// a split adds a write of the child entry through the single RAM write port.
// Reset: synchronous; control state and entry valid bits clear at once, the
// table reads as its reset contents with no clearing pass; root_quota is 0.
// ----------------------------------------------------------------------------
module page_quota_container_table
  import pqct_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  req_t              in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rsp_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [PAGE_W-1:0] cfg_data
);

  logic [PAGE_W-1:0] root_quota;
  logic              q_valid;
  op_t               q_data;
  logic              q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_quota <= '0;
    end else if (cfg_valid && cfg_ready) begin
      root_quota <= cfg_data;
    end
  end

  pqct_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  pqct_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .root_quota(root_quota),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/pqct_checker.sv
// ----------------------------------------------------------------------------
// pqct_checker
// Port-level checks for the page quota container table, bound to the top.
// ----------------------------------------------------------------------------
module pqct_checker
  import pqct_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input rsp_t              out_data
);

  // response beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("response beat changed while stalled");

  // failed split reports the table size as child id
  a_split_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.ok && out_data.new_child != '0
      |-> out_data.new_child == CHILD_W'(TABLE_SIZE))
    else $error("bad child id on failed split");

  // successful split leaves the parent with at least one child
  a_split_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.ok && out_data.new_child != '0
      |-> out_data.entry_children != '0 && out_data.new_child < CHILD_W'(TABLE_SIZE))
    else $error("split reported without a child on the parent");

  // an entry that is not in use has no quota and no parent
  a_idle_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.entry_in_use
      |-> out_data.entry_quota == '0 && out_data.entry_parent == '0)
    else $error("unused entry holds quota or parent");

endmodule

bind page_quota_container_table pqct_checker u_pqct_checker (.*);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for page_quota_container_table. A directed table
// covers reset contents, out-of-range ids, unknown codes, failed splits,
// usage saturation and a full quota. Random phases then grow container trees
// under several root quotas. Every response beat is checked against its fixed
// value or a table predictor; both sides idle at random but in the last phase.
// ----------------------------------------------------------------------------
module tb;
  import pqct_pkg::*;

  localparam int LIMIT      = 400000;
  localparam int DRAIN      = 12;
  localparam int PHASE_LEN  = 195;
  localparam int AMOUNT_MAX = 1 << (PAGE_W - 1);
  localparam logic [PAGE_W-1:0] PAGE_FULL = '1;
  localparam logic [CHILD_W-1:0] NO_CHILD = CHILD_W'(TABLE_SIZE);

  typedef struct {
    bit                is_cfg;
    logic [PAGE_W-1:0] cfg_val;
    req_t              req;
    bit                typed;
    rsp_t              want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  req_t              in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  rsp_t              out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [PAGE_W-1:0] cfg_data = '0;

  // predicted table contents
  logic [PAGE_W-1:0]   quota_tbl  [TABLE_SIZE];
  logic [PAGE_W-1:0]   usage_tbl  [TABLE_SIZE];
  logic [PARENT_W-1:0] parent_tbl [TABLE_SIZE];
  logic [CHILD_W-1:0]  kids_tbl   [TABLE_SIZE];
  logic                live_tbl   [TABLE_SIZE];
  logic [PAGE_W-1:0]   root_quota_reg;

  rsp_t      rsp_due [$];
  plan_row_t plan [$];

  bit calm = 1'b0;
  int errors = 0;
  int cycles = 0;
  int n_items = 0;
  int n_rsp = 0;
  int n_cfg = 0;
  int n_split_ok = 0;
  int n_init = 0;
  int sink_hold = 0;

  page_quota_container_table dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void clear_tables();
    int k;
    for (k = 0; k < TABLE_SIZE; k++) begin
      quota_tbl[k]  = '0;
      usage_tbl[k]  = '0;
      parent_tbl[k] = '0;
      kids_tbl[k]   = '0;
      live_tbl[k]   = 1'b0;
    end
    quota_tbl[0] = root_quota_reg;
    live_tbl[0]  = 1'b1;
  endfunction

  function automatic bit has_room(int ix, logic [PAGE_W-1:0] pages);
    if (usage_tbl[ix] > quota_tbl[ix]) return 1'b0;
    return (quota_tbl[ix] - usage_tbl[ix]) >= pages;
  endfunction

  function automatic rsp_t apply_cmd(req_t r);
    rsp_t            o;
    bit              in_rng;
    int              ix;
    int              cand;
    logic [PAGE_W:0] sum;
    o      = '0;
    in_rng = r.id < TABLE_SIZE;
    ix     = in_rng ? int'(r.id) : 0;
    case (r.cmd)
      CMD_CHECK: begin
        if (in_rng && has_room(ix, r.amount)) o.ok = 1'b1;
      end
      CMD_SPLIT: begin
        o.new_child = NO_CHILD;
        if (in_rng) begin
          cand = ix + int'(kids_tbl[ix]) + 1;
          if (cand < TABLE_SIZE) begin
            sum              = {1'b0, usage_tbl[ix]} + {1'b0, r.amount};
            usage_tbl[ix]    = sum[PAGE_W] ? PAGE_FULL : sum[PAGE_W-1:0];
            kids_tbl[ix]     = kids_tbl[ix] + 1'b1;
            quota_tbl[cand]  = r.amount;
            usage_tbl[cand]  = '0;
            parent_tbl[cand] = PARENT_W'(ix);
            kids_tbl[cand]   = '0;
            live_tbl[cand]   = 1'b1;
            o.new_child      = CHILD_W'(cand);
            o.ok             = 1'b1;
            n_split_ok++;
          end
        end
      end
      CMD_CHARGE: begin
        if (in_rng && has_room(ix, PAGE_W'(1))) begin
          usage_tbl[ix] = usage_tbl[ix] + 1'b1;
          o.ok          = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (in_rng && r.release_valid) begin
          if (usage_tbl[ix] != '0) usage_tbl[ix] = usage_tbl[ix] - 1'b1;
          o.ok = 1'b1;
        end
      end
      CMD_INIT: begin
        clear_tables();
        o.ok = 1'b1;
        n_init++;
      end
      default: ;
    endcase
    if (in_rng) begin
      o.entry_quota    = quota_tbl[ix];
      o.entry_usage    = usage_tbl[ix];
      o.entry_parent   = parent_tbl[ix];
      o.entry_children = kids_tbl[ix];
      o.entry_in_use   = live_tbl[ix];
    end
    return o;
  endfunction

  function automatic logic [ID_W-1:0] pick_live();
    int k;
    int c;
    for (k = 0; k < 8; k++) begin
      c = $urandom_range(0, TABLE_SIZE - 1);
      if (live_tbl[c]) return ID_W'(c);
    end
    return '0;
  endfunction

  function automatic req_t gen_req();
    req_t r;
    int   roll;
    r.id            = pick_live();
    r.amount        = PAGE_W'($urandom_range(0, 64));
    r.release_valid = ($urandom_range(0, 7) != 0);
    roll            = $urandom_range(0, 99);
    if (roll < 2) r.cmd = CMD_INIT;
    else if (roll < 35) r.cmd = CMD_SPLIT;
    else if (roll < 60) r.cmd = CMD_CHARGE;
    else if (roll < 80) r.cmd = CMD_RELEASE;
    else if (roll < 99) r.cmd = CMD_CHECK;
    else r.cmd = CMD_W'($urandom_range(int'(CMD_INIT) + 1, (1 << CMD_W) - 1));
    if ($urandom_range(0, 9) == 0) r.amount = PAGE_W'($urandom_range(0, AMOUNT_MAX));
    if ($urandom_range(0, 19) == 0) r.id = ID_W'($urandom_range(TABLE_SIZE, (1 << ID_W) - 1));
    return r;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  task automatic send_req(req_t r, bit typed, rsp_t fixed);
    rsp_t guess;
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    guess = apply_cmd(r);
    rsp_due.push_back(typed ? fixed : guess);
    n_items++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic write_root_quota(logic [PAGE_W-1:0] v);
    in_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    root_quota_reg = v;
    n_cfg++;
  endtask

  task automatic plan_cfg(logic [PAGE_W-1:0] v);
    plan_row_t p;
    p        = '{default: '0};
    p.is_cfg = 1'b1;
    p.cfg_val = v;
    plan.push_back(p);
  endtask

  task automatic plan_cmd(logic [CMD_W-1:0] c, int id, int amt, bit rv);
    plan_row_t p;
    p                     = '{default: '0};
    p.req.cmd             = c;
    p.req.id              = ID_W'(id);
    p.req.amount          = PAGE_W'(amt);
    p.req.release_valid   = rv;
    plan.push_back(p);
  endtask

  task automatic plan_typed(logic [CMD_W-1:0] c, int id, int amt, bit rv,
                            bit ok, int child, int q, int u, int par, int kids, bit live);
    plan_row_t p;
    p                     = '{default: '0};
    p.req.cmd             = c;
    p.req.id              = ID_W'(id);
    p.req.amount          = PAGE_W'(amt);
    p.req.release_valid   = rv;
    p.typed               = 1'b1;
    p.want.ok             = ok;
    p.want.new_child      = CHILD_W'(child);
    p.want.entry_quota    = PAGE_W'(q);
    p.want.entry_usage    = PAGE_W'(u);
    p.want.entry_parent   = PARENT_W'(par);
    p.want.entry_children = CHILD_W'(kids);
    p.want.entry_in_use   = live;
    plan.push_back(p);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, rsp_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result sink with random back-pressure
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      sink_hold <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
      sink_hold <= $urandom_range(0, 30);
    end
  end

  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && out_valid && out_ready) begin
      n_rsp++;
      if (rsp_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, got %h", $time, out_data);
      end else begin
        want = rsp_due.pop_front();
        check_field("ok", want.ok, out_data.ok);
        check_field("new_child", want.new_child, out_data.new_child);
        check_field("entry_quota", want.entry_quota, out_data.entry_quota);
        check_field("entry_usage", want.entry_usage, out_data.entry_usage);
        check_field("entry_parent", want.entry_parent, out_data.entry_parent);
        check_field("entry_children", want.entry_children, out_data.entry_children);
        check_field("entry_in_use", want.entry_in_use, out_data.entry_in_use);
      end
    end
  end

  initial begin : stim
    int   ph;
    int   k;
    req_t r;
    logic [PAGE_W-1:0] phase_quota;
    root_quota_reg = '0;
    clear_tables();

    // reset contents, root quota zero
    plan_typed(CMD_CHECK,   0,   0, 0, 1, 0, 0, 0, 0, 0, 1);
    plan_typed(CMD_CHARGE,  0,   0, 0, 0, 0, 0, 0, 0, 0, 1);
    plan_typed(CMD_RELEASE, 0,   0, 1, 1, 0, 0, 0, 0, 0, 1);
    plan_typed(CMD_RELEASE, 5,   0, 1, 1, 0, 0, 0, 0, 0, 0);
    plan_typed(CMD_CHECK,   255, AMOUNT_MAX, 0, 0, 0, 0, 0, 0, 0, 0);
    plan_typed(CMD_SPLIT,   63,  7, 0, 0, TABLE_SIZE, 0, 0, 0, 0, 0);
    plan_typed(CMD_SPLIT,   200, 7, 0, 0, TABLE_SIZE, 0, 0, 0, 0, 0);
    plan_typed(CMD_CHARGE,  64,  0, 1, 0, 0, 0, 0, 0, 0, 0);
    plan_typed(CMD_INIT + 3'd1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1);
    plan_typed(CMD_W'((1 << CMD_W) - 1), 170, 0, 1, 0, 0, 0, 0, 0, 0, 0);
    // root quota of AMOUNT_MAX, saturating usage
    plan_cfg(PAGE_W'(AMOUNT_MAX));
    plan_typed(CMD_INIT,    255, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    plan_typed(CMD_CHECK,   0, AMOUNT_MAX, 0, 1, 0, AMOUNT_MAX, 0, 0, 0, 1);
    plan_typed(CMD_SPLIT,   0, AMOUNT_MAX, 0, 1, 1, AMOUNT_MAX, AMOUNT_MAX, 0, 1, 1);
    plan_typed(CMD_SPLIT,   0, AMOUNT_MAX, 0, 1, 2, AMOUNT_MAX, int'(PAGE_FULL), 0, 2, 1);
    plan_typed(CMD_CHECK,   0, 0, 0, 0, 0, AMOUNT_MAX, int'(PAGE_FULL), 0, 2, 1);
    plan_typed(CMD_CHARGE,  0, 0, 0, 0, 0, AMOUNT_MAX, int'(PAGE_FULL), 0, 2, 1);
    plan_typed(CMD_CHECK,   1, AMOUNT_MAX - 1, 0, 1, 0, AMOUNT_MAX, 0, 0, 0, 1);
    plan_typed(CMD_CHARGE,  1, 0, 0, 1, 0, AMOUNT_MAX, 1, 0, 0, 1);
    plan_typed(CMD_RELEASE, 1, 0, 0, 0, 0, AMOUNT_MAX, 1, 0, 0, 1);
    plan_typed(CMD_RELEASE, 1, 0, 1, 1, 0, AMOUNT_MAX, 0, 0, 0, 1);
    plan_cmd(CMD_SPLIT, 2, AMOUNT_MAX - 1, 0);
    plan_cfg(PAGE_W'(AMOUNT_MAX - 1));
    plan_typed(CMD_INIT,    0, 0, 0, 1, 0, AMOUNT_MAX - 1, 0, 0, 0, 1);
    plan_cmd(CMD_SPLIT, 62, 5, 0);
    plan_cmd(CMD_SPLIT, 62, 5, 0);
    plan_cmd(CMD_RELEASE, 63, 0, 1);
    plan_cfg('0);
    plan_typed(CMD_INIT,    9, 0, 0, 1, 0, 0, 0, 0, 0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].is_cfg) write_root_quota(plan[k].cfg_val);
      else send_req(plan[k].req, plan[k].typed, plan[k].want);
    end

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: phase_quota = PAGE_W'(AMOUNT_MAX);
        1: phase_quota = PAGE_W'($urandom_range(1, 300));
        2: phase_quota = '0;
        3: phase_quota = PAGE_W'($urandom_range(0, AMOUNT_MAX));
        default: phase_quota = PAGE_W'($urandom_range(20, 2000));
      endcase
      write_root_quota(phase_quota);
      if (ph == 4) calm = 1'b1;
      r        = '0;
      r.cmd    = CMD_INIT;
      r.id     = ID_W'($urandom_range(0, (1 << ID_W) - 1));
      send_req(r, 1'b0, '0);
      for (k = 0; k < PHASE_LEN; k++) send_req(gen_req(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d commands and %0d result beats under %0d root quota writes",
             n_items, n_rsp, n_cfg);
    $display("including %0d successful splits and %0d table inits", n_split_ok, n_init);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/pqct_pkg.sv
rtl/pqct_ram.sv
rtl/pqct_front.sv
rtl/pqct_back.sv
rtl/page_quota_container_table.sv
rtl/pqct_checker.sv
tb/tb.sv
